// ===== src/min_max_split_size_search_top_macros.svh =====
// assertion macros for the split size search block
`ifndef MIN_MAX_SPLIT_SIZE_SEARCH_TOP_MACROS_SVH
`define MIN_MAX_SPLIT_SIZE_SEARCH_TOP_MACROS_SVH

// condition holds on every edge outside reset
`define MMSS_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent on the next edge, outside reset
`define MMSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// antecedent implies consequent on the next edge, reset included
`define MMSS_ASSERT_NEXT_ANY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/mmss_pkg.sv =====
package mmss_pkg;

  localparam int MAX_ITEMS   = 1024;
  localparam int VALUE_BITS  = 16;
  localparam int ADDR_BITS   = $clog2(MAX_ITEMS);
  localparam int COUNT_BITS  = ADDR_BITS + 1;
  localparam int BUDGET_BITS = 26;
  localparam int STEP_BITS   = $clog2(VALUE_BITS + 1);

  localparam logic [BUDGET_BITS-1:0] TOTAL_SAT = {BUDGET_BITS{1'b1}};

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CHECK,
    ST_READ,
    ST_START,
    ST_WAIT,
    ST_EVAL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic done;
  } div_sts_t;

endpackage

// ===== src/mmss_div.sv =====
module mmss_div (
  input  logic                            clk,
  input  logic                            rst,
  input  mmss_pkg::div_ctl_t              ctl,
  input  logic [mmss_pkg::VALUE_BITS-1:0] dividend,
  input  logic [mmss_pkg::VALUE_BITS-1:0] divisor,
  output mmss_pkg::div_sts_t              sts,
  output logic [mmss_pkg::VALUE_BITS-1:0] quotient
);

  logic                             busy;
  logic                             done;
  logic [mmss_pkg::STEP_BITS-1:0]   steps;
  logic [mmss_pkg::VALUE_BITS:0]    rem;
  logic [mmss_pkg::VALUE_BITS-1:0]  quo;
  logic [mmss_pkg::VALUE_BITS:0]    shifted;
  logic [mmss_pkg::VALUE_BITS:0]    dvs;
  logic                             fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem[mmss_pkg::VALUE_BITS-1:0], quo[mmss_pkg::VALUE_BITS-1]};
    dvs     = {1'b0, divisor};
    fits    = (shifted >= dvs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        steps <= mmss_pkg::STEP_BITS'(mmss_pkg::VALUE_BITS);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == mmss_pkg::STEP_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? (shifted - dvs) : shifted;
      quo <= {quo[mmss_pkg::VALUE_BITS-2:0], fits};
    end
  end

  assign sts.done = done;
  assign quotient = quo;

endmodule

// ===== src/min_max_split_size_search_top.sv =====
// split size search: smallest limit whose total split count fits a budget
//
// s_* channel: one bag size per item in s_tdata, s_tlast on the final one.
// m_* channel: one item per set, the smallest limit, after the set closes.
// cfg_we / cfg_data write the split budget; write only while idle.
//
// loading takes one item per cycle; up to 1024 values are held, more are
// dropped. after the final item the block stops taking items and runs a
// binary search from 1 up to the largest value. each pass reads every held
// value once from the value memory and divides it, less one, by the trial
// limit in a bit-serial divider; zero values are not divided. passes = bit
// length of the largest value at most. the result waits in its output
// register while m_tready is low; no new item is taken until it has been
// delivered. reset (rst, synchronous) empties the set and sets the budget to
// zero; no memory clearing is done.
module min_max_split_size_search_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [15:0]                      s_tdata,   // item_value
  input  logic                             s_tlast,   // last_item
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [15:0]                      m_tdata,   // smallest_limit
  input  logic                             cfg_we,
  input  logic [mmss_pkg::BUDGET_BITS-1:0] cfg_data
);

  localparam int VB = mmss_pkg::VALUE_BITS;
  localparam int AB = mmss_pkg::ADDR_BITS;
  localparam int CB = mmss_pkg::COUNT_BITS;
  localparam int BB = mmss_pkg::BUDGET_BITS;

  mmss_pkg::state_t state, state_next;

  logic [VB-1:0] value_store [mmss_pkg::MAX_ITEMS];
  logic [VB-1:0] rd_data;

  logic [BB-1:0] split_budget;
  logic [CB-1:0] stored_count;
  logic [VB-1:0] largest_value;
  logic [VB:0]   search_low;
  logic [VB:0]   search_high;
  logic [VB-1:0] best_limit;
  logic [VB-1:0] mid;
  logic [BB-1:0] split_total;
  logic [AB-1:0] scan_index;

  logic          s_accept;
  logic          store_ok;
  logic [VB-1:0] in_value;
  logic [VB-1:0] largest_next;
  logic [VB:0]   mid_calc;
  logic [CB-1:0] scan_step;
  logic          scan_end;
  logic [BB:0]   sum;

  mmss_pkg::div_ctl_t div_ctl;
  mmss_pkg::div_sts_t div_sts;
  logic [VB-1:0]      div_quo;

  mmss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (rd_data - 1'b1),
    .divisor  (mid),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  always_comb begin
    s_accept     = s_tvalid && s_tready;
    in_value     = s_tdata[VB-1:0];
    store_ok     = (stored_count < CB'(mmss_pkg::MAX_ITEMS));
    largest_next = (store_ok && (in_value > largest_value)) ? in_value : largest_value;
    mid_calc     = search_low + ((search_high - search_low) >> 1);
    scan_step    = {1'b0, scan_index} + 1'b1;
    scan_end     = (scan_step == stored_count);
    sum          = {1'b0, split_total} + (BB + 1)'(div_quo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmss_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    m_tvalid      = 1'b0;
    div_ctl.start = 1'b0;
    case (state)
      mmss_pkg::ST_LOAD: begin
        s_tready = 1'b1;
        if (s_tvalid && s_tlast) begin
          state_next = mmss_pkg::ST_CHECK;
        end
      end
      mmss_pkg::ST_CHECK: begin
        state_next = (search_low <= search_high) ? mmss_pkg::ST_READ : mmss_pkg::ST_OUT;
      end
      mmss_pkg::ST_READ: begin
        state_next = mmss_pkg::ST_START;
      end
      mmss_pkg::ST_START: begin
        if (rd_data != '0) begin
          div_ctl.start = 1'b1;
          state_next    = mmss_pkg::ST_WAIT;
        end else begin
          state_next = scan_end ? mmss_pkg::ST_EVAL : mmss_pkg::ST_READ;
        end
      end
      mmss_pkg::ST_WAIT: begin
        if (div_sts.done) begin
          state_next = scan_end ? mmss_pkg::ST_EVAL : mmss_pkg::ST_READ;
        end
      end
      mmss_pkg::ST_EVAL: begin
        state_next = mmss_pkg::ST_CHECK;
      end
      mmss_pkg::ST_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          state_next = mmss_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = mmss_pkg::ST_LOAD;
      end
    endcase
  end

  // value memory, registered read
  always_ff @(posedge clk) begin
    if (s_accept && store_ok) begin
      value_store[stored_count[AB-1:0]] <= in_value;
    end
    rd_data <= value_store[scan_index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      split_budget  <= '0;
    end else if (cfg_we) begin
      split_budget  <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count  <= '0;
      largest_value <= '0;
    end else if (s_accept) begin
      if (store_ok) begin
        stored_count <= stored_count + 1'b1;
      end
      largest_value <= largest_next;
    end else if (state == mmss_pkg::ST_OUT && m_tready) begin
      stored_count  <= '0;
      largest_value <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      search_low  <= (VB + 1)'(1);
      search_high <= '0;
      best_limit  <= '0;
      split_total <= '0;
      scan_index  <= '0;
      mid         <= '0;
    end else begin
      case (state)
        mmss_pkg::ST_LOAD: begin
          if (s_accept && s_tlast) begin
            search_low  <= (VB + 1)'(1);
            search_high <= {1'b0, largest_next};
            best_limit  <= largest_next;
          end
        end
        mmss_pkg::ST_CHECK: begin
          mid         <= mid_calc[VB-1:0];
          split_total <= '0;
          scan_index  <= '0;
        end
        mmss_pkg::ST_START: begin
          if (rd_data == '0) begin
            scan_index <= scan_step[AB-1:0];
          end
        end
        mmss_pkg::ST_WAIT: begin
          if (div_sts.done) begin
            split_total <= sum[BB] ? mmss_pkg::TOTAL_SAT : sum[BB-1:0];
            scan_index  <= scan_step[AB-1:0];
          end
        end
        mmss_pkg::ST_EVAL: begin
          if (split_total <= split_budget) begin
            best_limit  <= mid;
            search_high <= {1'b0, mid} - 1'b1;
          end else begin
            search_low  <= {1'b0, mid} + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign m_tdata = 16'(best_limit);

endmodule

// ===== src/mmss_checker.sv =====
`include "min_max_split_size_search_top_macros.svh"

module mmss_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  `MMSS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item changed while stalled")
  `MMSS_ASSERT_ALWAYS(a_no_overlap, !(s_tready && m_tvalid), "input taken while a result is pending")
  `MMSS_ASSERT_NEXT(a_one_result, m_tvalid && m_tready, !m_tvalid, "more than one result item per set")
  `MMSS_ASSERT_NEXT(a_last_closes, s_tvalid && s_tready && s_tlast, !s_tready, "input still taken after last item")
  `MMSS_ASSERT_NEXT_ANY(a_reset_state, rst, s_tready && !m_tvalid, "block not idle after reset")

endmodule

bind min_max_split_size_search_top mmss_checker u_mmss_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import mmss_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [BUDGET_BITS-1:0] BUDGET_MAX = {BUDGET_BITS{1'b1}};

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [15:0]            s_tdata  = '0;  // item_value
  logic                   s_tlast  = 1'b0;  // last_item
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [15:0]            m_tdata;  // smallest_limit
  logic                   cfg_we   = 1'b0;
  logic [BUDGET_BITS-1:0] cfg_data = '0;

  int src_idle_pct = 31;
  int snk_idle_pct = 73;
  int stall_left   = 0;
  int err_count    = 0;
  int cycle_count  = 0;

  // predictor state: sizes of the open set, its peak, the budget in force
  logic [15:0]            held_sizes[$];
  logic [15:0]            peak_size  = '0;
  logic [BUDGET_BITS-1:0] budget_now = '0;
  logic [15:0]            expected_limits[$];
  logic [15:0]            want_limit;

  always #5 clk = ~clk;

  min_max_split_size_search_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  function automatic longint splits_at(longint limit);
    longint total;
    total = 0;
    foreach (held_sizes[i]) begin
      if (held_sizes[i] != 0) begin
        total += (longint'(held_sizes[i]) - 1) / limit;
        if (total > longint'(TOTAL_SAT)) total = longint'(TOTAL_SAT);
      end
    end
    return total;
  endfunction

  // binary search for the least limit whose split count fits the budget
  function automatic logic [15:0] min_limit();
    longint lo, hi, best, mid;
    lo   = 1;
    hi   = peak_size;
    best = peak_size;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (splits_at(mid) <= longint'(budget_now)) begin
        best = mid;
        hi   = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return best[15:0];
  endfunction

  task automatic track_item(input logic [15:0] v, input logic l);
    if (held_sizes.size() < MAX_ITEMS) begin
      held_sizes.push_back(v);
      if (v > peak_size) peak_size = v;
    end
    if (l) begin
      expected_limits.push_back(min_limit());
      held_sizes.delete();
      peak_size = '0;
    end
  endtask

  task automatic send_item(input logic [15:0] v, input logic l);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    track_item(v, l);
  endtask

  // wait until every expected limit has come back and the block is idle
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_limits.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_budget(input logic [BUDGET_BITS-1:0] b);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= b;
    @(posedge clk);
    cfg_we     <= 1'b0;
    budget_now = b;
  endtask

  function automatic logic [15:0] rand_size();
    int r;
    r = $urandom_range(19);
    if (r == 0) return 16'd0;
    if (r <= 2) return 16'hFFFF;
    if (r <= 5) return 16'd1 << $urandom_range(15);
    if (r <= 10) return 16'($urandom_range(1, 16));
    return 16'($urandom_range(1, 65535));
  endfunction

  function automatic logic [BUDGET_BITS-1:0] rand_budget();
    case ($urandom_range(5))
      0: return '0;
      1: return BUDGET_MAX;
      2: return BUDGET_BITS'($urandom_range(0, 32'h3FF_FFFF));
      default: return BUDGET_BITS'($urandom_range(0, 200));
    endcase
  endfunction

  task automatic send_set(input int n);
    for (int i = 0; i < n; i++) send_item(rand_size(), i == n - 1);
  endtask

  task automatic test_directed();
    // reset budget of zero: the answer is the peak
    send_item(16'hFFFF, 1'b1);
    send_item(16'd1, 1'b1);
    send_item(16'd0, 1'b1);  // all zero
    send_item(16'd0, 1'b0);
    send_item(16'd0, 1'b0);
    send_item(16'd7, 1'b1);
    write_budget(BUDGET_MAX);
    send_item(16'h5555, 1'b0);
    send_item(16'hAAAA, 1'b0);
    send_item(16'd0, 1'b0);
    send_item(16'hFFFF, 1'b1);
    write_budget(1);
    send_item(16'd9, 1'b0);
    send_item(16'd3, 1'b1);
    write_budget(3);
    send_item(16'h8000, 1'b0);
    send_item(16'h7FFF, 1'b0);
    send_item(16'd1, 1'b1);
    write_budget(1000);
    send_item(16'hFFFE, 1'b0);
    send_item(16'h0100, 1'b0);
    send_item(16'h00FF, 1'b1);
  endtask

  task automatic test_random(input int n_items);
    int sent, n;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) write_budget(rand_budget());
      n = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      send_set(n);
      sent += n;
    end
  endtask

  // receiver holds off while sets keep coming, so the input stalls
  task automatic test_backpressure();
    settle();
    src_idle_pct = 0;
    stall_left   = 3000;
    for (int k = 0; k < 3; k++) send_set($urandom_range(1, 4));
    settle();
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_limits.size() == 0) begin
        $error("smallest_limit: unexpected item, actual %0d", m_tdata);
        err_count++;
      end else begin
        want_limit = expected_limits.pop_front();
        if (m_tdata !== want_limit) begin
          $error("smallest_limit: expected %0d, actual %0d", want_limit, m_tdata);
          err_count++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    src_idle_pct = 31;
    snk_idle_pct = 73;
    test_random(135);
    src_idle_pct = 73;
    snk_idle_pct = 31;
    test_random(135);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random(135);
    test_backpressure();
    settle();
    if (expected_limits.size() != 0) begin
      $error("smallest_limit: %0d results never arrived", expected_limits.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
